// ===== sv/mbtcp_pkg.sv =====
// Package for the Modbus TCP register server: frame positions, function codes
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbtcp_pkg;

  localparam int unsigned HDR_BYTES     = 12;
  localparam logic [8:0]  HDR_LEN       = 9'd12;
  localparam logic [8:0]  PAYLOAD_START = 9'd13;
  localparam logic [8:0]  POS_MAX       = 9'd511;
  localparam logic [8:0]  RD_FIXED      = 9'd9;
  localparam logic [7:0]  WR_LEN_FIELD  = 8'd6;
  localparam logic [7:0]  RD_LEN_EXTRA  = 8'd3;

  localparam logic [7:0]  FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0]  FC_WRITE_MULTI   = 8'd16;
  localparam logic [15:0] MAX_REGS         = 16'd125;

  // Header byte positions
  localparam logic [3:0]  HDR_UNIT      = 4'd6;
  localparam logic [3:0]  HDR_FUNC      = 4'd7;
  localparam logic [3:0]  HDR_START_HI  = 4'd8;
  localparam logic [3:0]  HDR_START_LO  = 4'd9;
  localparam logic [3:0]  HDR_COUNT_HI  = 4'd10;
  localparam logic [3:0]  HDR_COUNT_LO  = 4'd11;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/modbus_tcp_register_server.sv =====
// Modbus TCP holding-register server (read holding registers, write multiple
// registers) over a byte stream. Depends on mbtcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Request bytes (in_func = 0) enter MBAP header first; the first twelve are
// latched and the payload of a write multiple registers frame goes straight
// into the register bank. On the byte flagged in_rx_last a response is armed
// for function codes 3 and 16 if the frame held a full header and a count of
// at most 125; each tick item (in_func = 1) then yields one response byte,
// out_tx_last marking the final one. Request bytes are dropped while a
// response is pending. The bank is two byte-wide synchronous RAMs of
// BANK_WORDS entries, high and low bytes. After reset the bank is cleared by
// a pass over all entries during which no item is accepted. A request byte,
// or a tick with no response pending, leaves the server ready; a tick
// yielding a byte holds off items until the byte enters the result register.
module modbus_tcp_register_server #(
  parameter int BANK_WORDS = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_rx_last,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_tx_byte,
  output      logic       out_tx_last
);
  import mbtcp_pkg::*;

  localparam int          AW         = $clog2(BANK_WORDS);
  localparam logic [16:0] BANK_LIMIT = 17'(BANK_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(BANK_WORDS - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r;
  logic [7:0]    mem_hi [BANK_WORDS];
  logic [7:0]    mem_lo [BANK_WORDS];
  logic [7:0]    rd_hi_r, rd_lo_r;

  logic [7:0] hdr_r   [HDR_BYTES];
  logic [7:0] hdr_fwd [HDR_BYTES];

  logic [8:0] rx_pos_r, rx_pos_nxt, rx_pos_inc;
  logic [8:0] tx_pos_r, tx_pos_nxt;
  logic [8:0] tx_len_r, tx_len_nxt;
  logic       resp_r, resp_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       pend_bank_r, pend_inrng_r, pend_odd_r, pend_last_r;
  logic [7:0] pend_byte_r;

  logic accept, rx_acc, tick_emit, out_load, clr_we;

  logic [15:0] hdr_count, hdr_start, cnt_fwd;
  logic [7:0]  fc, fc_fwd, two_n8;
  logic        count_ok;

  logic [8:0]  pay_k, two_n9;
  logic [16:0] wr_addr;
  logic        hdr_we, wr_en, wr_hi, wr_lo;

  logic        arm;
  logic [8:0]  arm_len;

  logic [8:0]  rd_k;
  logic [16:0] rd_addr;
  logic [7:0]  resp_byte, hdr_at_tx;
  logic        resp_bank, resp_last;

  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          we_hi, we_lo, mem_re;
  logic [7:0]    emit_byte;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (tick_emit) state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    clr_we   = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_EMIT:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign rx_acc    = accept && !in_func;
  assign tick_emit = accept && in_func && resp_r;

  // ---------------------------------------------------------------- header
  assign hdr_count = {hdr_r[HDR_COUNT_HI], hdr_r[HDR_COUNT_LO]};
  assign hdr_start = {hdr_r[HDR_START_HI], hdr_r[HDR_START_LO]};
  assign fc        = hdr_r[HDR_FUNC];
  assign count_ok  = hdr_count <= MAX_REGS;
  assign two_n8    = {hdr_count[6:0], 1'b0};
  assign two_n9    = {hdr_count[7:0], 1'b0};

  assign hdr_we = rx_acc && !resp_r && (rx_pos_r < HDR_LEN);

  // Forward the byte being latched so a frame ending on it sees it
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_fwd[i] = (hdr_we && rx_pos_r[3:0] == 4'(i)) ? in_rx_byte : hdr_r[i];
    end
  end

  assign fc_fwd  = hdr_fwd[HDR_FUNC];
  assign cnt_fwd = {hdr_fwd[HDR_COUNT_HI], hdr_fwd[HDR_COUNT_LO]};

  // ---------------------------------------------------------------- receive
  assign pay_k   = rx_pos_r - PAYLOAD_START;
  assign wr_addr = {1'b0, hdr_start} + 17'(pay_k[8:1]);
  assign wr_en   = rx_acc && !resp_r && (rx_pos_r >= PAYLOAD_START)
                   && (fc == FC_WRITE_MULTI) && count_ok && (pay_k < two_n9)
                   && (wr_addr < BANK_LIMIT);
  assign wr_hi   = wr_en && !pay_k[0];
  assign wr_lo   = wr_en && pay_k[0];

  assign rx_pos_inc = (rx_pos_r < POS_MAX) ? rx_pos_r + 9'd1 : rx_pos_r;

  assign arm = rx_acc && !resp_r && in_rx_last && (rx_pos_inc >= HDR_LEN)
               && (cnt_fwd <= MAX_REGS)
               && (fc_fwd == FC_READ_HOLDING || fc_fwd == FC_WRITE_MULTI);
  assign arm_len = (fc_fwd == FC_READ_HOLDING) ? RD_FIXED + {cnt_fwd[7:0], 1'b0}
                                               : HDR_LEN;

  always_comb begin
    rx_pos_nxt = rx_pos_r;
    if (rx_acc) begin
      if (in_rx_last) begin
        rx_pos_nxt = '0;
      end else if (!resp_r) begin
        rx_pos_nxt = rx_pos_inc;
      end
    end
  end

  // ---------------------------------------------------------------- respond
  assign rd_k      = tx_pos_r - RD_FIXED;
  assign rd_addr   = {1'b0, hdr_start} + 17'(rd_k[8:1]);
  assign hdr_at_tx = (tx_pos_r < HDR_LEN) ? hdr_r[tx_pos_r[3:0]] : 8'd0;
  assign resp_last = (tx_pos_r + 9'd1) >= tx_len_r;

  always_comb begin
    resp_byte = 8'd0;
    resp_bank = 1'b0;
    if (tx_pos_r < 9'd4) begin
      resp_byte = hdr_at_tx;
    end else if (tx_pos_r == 9'd4) begin
      resp_byte = 8'd0;
    end else if (fc == FC_READ_HOLDING) begin
      if (tx_pos_r == 9'd5) begin
        resp_byte = two_n8 + RD_LEN_EXTRA;
      end else if (tx_pos_r == 9'(HDR_UNIT) || tx_pos_r == 9'(HDR_FUNC)) begin
        resp_byte = hdr_at_tx;
      end else if (tx_pos_r == 9'd8) begin
        resp_byte = two_n8;
      end else begin
        resp_bank = 1'b1;
      end
    end else if (tx_pos_r == 9'd5) begin
      resp_byte = WR_LEN_FIELD;
    end else begin
      resp_byte = hdr_at_tx;
    end
  end

  always_comb begin
    tx_pos_nxt = tx_pos_r;
    tx_len_nxt = tx_len_r;
    resp_nxt   = resp_r;
    if (arm) begin
      tx_len_nxt = arm_len;
      tx_pos_nxt = '0;
      resp_nxt   = 1'b1;
    end else if (tick_emit) begin
      if (resp_last) begin
        tx_pos_nxt = '0;
        tx_len_nxt = '0;
        resp_nxt   = 1'b0;
      end else begin
        tx_pos_nxt = tx_pos_r + 9'd1;
      end
    end
  end

  // ---------------------------------------------------------------- bank RAMs
  assign mem_wa = clr_we ? clr_cnt_r : wr_addr[AW-1:0];
  assign mem_wd = clr_we ? 8'd0 : in_rx_byte;
  assign we_hi  = clr_we || wr_hi;
  assign we_lo  = clr_we || wr_lo;
  assign mem_re = tick_emit && resp_bank;

  always_ff @(posedge clk) begin
    if (we_hi) mem_hi[mem_wa] <= mem_wd;
    if (mem_re) rd_hi_r <= mem_hi[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_lo) mem_lo[mem_wa] <= mem_wd;
    if (mem_re) rd_lo_r <= mem_lo[rd_addr[AW-1:0]];
  end

  // Out-of-bank words read as zero
  assign emit_byte = !pend_bank_r ? pend_byte_r
                   : !pend_inrng_r ? 8'd0
                   : pend_odd_r ? rd_lo_r : rd_hi_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      rx_pos_r    <= '0;
      tx_pos_r    <= '0;
      tx_len_r    <= '0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rx_pos_r <= rx_pos_nxt;
      tx_pos_r <= tx_pos_nxt;
      tx_len_r <= tx_len_nxt;
      resp_r   <= resp_nxt;
      if (clr_we) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_r[i] <= hdr_fwd[i];
    end
    if (tick_emit) begin
      pend_bank_r  <= resp_bank;
      pend_inrng_r <= rd_addr < BANK_LIMIT;
      pend_odd_r   <= rd_k[0];
      pend_byte_r  <= resp_byte;
      pend_last_r  <= resp_last;
    end
    if (out_load) begin
      out_byte_r <= emit_byte;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_tx_last = out_last_r;

endmodule

`default_nettype wire

// ===== dv/modbus_tcp_register_server_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modbus_tcp_register_server: sends request frames and
// response ticks and checks each response byte against a behavioural server model.
// Depends on mbtcp_pkg and the server RTL.
module modbus_tcp_register_server_test;
  import mbtcp_pkg::*;

  localparam int BANK_WORDS   = 1024;
  localparam int HALF_PERIOD  = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_ITEMS  = 1450;
  localparam int QUIET_ITEMS  = 120;
  localparam int TAIL_CYCLES  = 16;

  localparam logic OP_REQ_BYTE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Frame positions not named in the package
  localparam int POS_LEN_HI        = 4;
  localparam int POS_LEN_LO        = 5;
  localparam int POS_RD_BYTE_COUNT = 8;
  localparam int POS_BYTE_COUNT    = 12;
  localparam logic [7:0] FC_OTHER    = 8'd4;
  localparam logic [7:0] FC_RESERVED = 8'hFF;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_func = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_rx_last = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;

  // Server model state
  logic [15:0] bank_m [BANK_WORDS];
  logic [7:0]  hdr_m [HDR_BYTES];
  logic [8:0]  rx_pos_m;
  logic [8:0]  tx_pos_m;
  logic [8:0]  tx_len_m;
  logic        busy_m;
  tx_item_t    tx_expected [$];

  int mismatches = 0;
  int cycle_count = 0;
  int useful_items = 0;
  int sent_items = 0;
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_off_len = 0;
  int hold_off_seq = 0;
  int hold_off_seen = 0;
  int hold_left = 0;

  modbus_tcp_register_server #(
    .BANK_WORDS (BANK_WORDS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_rx_byte  (in_rx_byte),
    .in_rx_last  (in_rx_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a new one is requested
  always @(posedge clk) begin
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_left = hold_off_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(out_idle_en && $urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin : check_tx
    tx_item_t want;
    if (out_valid && out_ready) begin
      if (tx_expected.size() == 0) begin
        $error("tx_byte %02h with no response byte pending", out_tx_byte);
        mismatches++;
      end else begin
        want = tx_expected.pop_front();
        if (out_tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_tx_byte);
          mismatches++;
        end
        if (out_tx_last !== want.tx_last) begin
          $error("tx_last: expected %0b, got %0b", want.tx_last, out_tx_last);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [7:0] tx_byte_at(logic [8:0] pos);
    logic [15:0] n;
    logic [15:0] w;
    int unsigned k;
    int unsigned addr;
    n = {hdr_m[HDR_COUNT_HI], hdr_m[HDR_COUNT_LO]};
    if (pos < POS_LEN_HI) return hdr_m[pos];
    if (pos == POS_LEN_HI) return 8'h00;
    if (hdr_m[HDR_FUNC] == FC_READ_HOLDING) begin
      if (pos == POS_LEN_LO) return 8'(2 * n + RD_LEN_EXTRA);
      if (pos == HDR_UNIT || pos == HDR_FUNC) return hdr_m[pos];
      if (pos == POS_RD_BYTE_COUNT) return 8'(2 * n);
      k = pos - RD_FIXED;
      addr = {hdr_m[HDR_START_HI], hdr_m[HDR_START_LO]} + k / 2;
      w = (addr < BANK_WORDS) ? bank_m[addr] : 16'h0000;
      return k[0] ? w[7:0] : w[15:8];
    end
    if (pos == POS_LEN_LO) return WR_LEN_FIELD;
    if (pos < HDR_BYTES) return hdr_m[pos];
    return 8'h00;
  endfunction

  function automatic void serve_item(logic func, logic [7:0] b, logic last);
    logic [15:0] n;
    logic [8:0]  len;
    int unsigned k;
    int unsigned addr;
    tx_item_t    r;
    if (func == OP_TICK) begin
      if (busy_m) begin
        r.tx_byte = tx_byte_at(tx_pos_m);
        r.tx_last = (tx_pos_m + 1 >= tx_len_m);
        tx_expected.push_back(r);
        useful_items++;
        tx_pos_m++;
        if (tx_pos_m >= tx_len_m) begin
          busy_m = 1'b0;
          tx_pos_m = '0;
          tx_len_m = '0;
        end
      end
      return;
    end
    if (busy_m) begin
      // drop the byte, but a frame end still realigns the receive position
      if (last) rx_pos_m = '0;
      return;
    end
    useful_items++;
    if (rx_pos_m < HDR_BYTES) begin
      hdr_m[rx_pos_m] = b;
    end else if (rx_pos_m >= PAYLOAD_START && hdr_m[HDR_FUNC] == FC_WRITE_MULTI) begin
      n = {hdr_m[HDR_COUNT_HI], hdr_m[HDR_COUNT_LO]};
      k = rx_pos_m - PAYLOAD_START;
      if (n <= MAX_REGS && k < 2 * n) begin
        addr = {hdr_m[HDR_START_HI], hdr_m[HDR_START_LO]} + k / 2;
        if (addr < BANK_WORDS) begin
          if (k[0]) bank_m[addr][7:0] = b;
          else bank_m[addr][15:8] = b;
        end
      end
    end
    if (rx_pos_m < POS_MAX) rx_pos_m++;
    if (last) begin
      len = rx_pos_m;
      rx_pos_m = '0;
      n = {hdr_m[HDR_COUNT_HI], hdr_m[HDR_COUNT_LO]};
      if (len >= HDR_LEN && n <= MAX_REGS) begin
        if (hdr_m[HDR_FUNC] == FC_READ_HOLDING) begin
          tx_len_m = RD_FIXED + 9'(2 * n);
          tx_pos_m = '0;
          busy_m = 1'b1;
        end else if (hdr_m[HDR_FUNC] == FC_WRITE_MULTI) begin
          tx_len_m = HDR_LEN;
          tx_pos_m = '0;
          busy_m = 1'b1;
        end
      end
    end
  endfunction

  task automatic send_item(logic func, logic [7:0] b, logic last);
    if (in_idle_en && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_rx_byte <= b;
    in_rx_last <= last;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    serve_item(func, b, last);
  endtask

  // Drop valid, then hold until every pending response byte has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_expected.size() != 0) @(posedge clk);
  endtask

  // fill < 0 gives random payload bytes, otherwise every payload byte is fill
  task automatic send_frame(logic [7:0] fc, logic [15:0] start, logic [15:0] count,
                            int nbytes, int fill);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case (i)
        HDR_FUNC:       b = fc;
        HDR_START_HI:   b = start[15:8];
        HDR_START_LO:   b = start[7:0];
        HDR_COUNT_HI:   b = count[15:8];
        HDR_COUNT_LO:   b = count[7:0];
        POS_BYTE_COUNT: b = $urandom_range(1) ? 8'(2 * count) : 8'($urandom);
        default:        b = (i > POS_BYTE_COUNT && fill >= 0) ? 8'(fill) : 8'($urandom);
      endcase
      send_item(OP_REQ_BYTE, b, i == nbytes - 1);
    end
  endtask

  task automatic pull_response(int noise_pct);
    while (busy_m) begin
      if ($urandom_range(99) < noise_pct)
        send_item(OP_REQ_BYTE, 8'($urandom), $urandom_range(3) == 0);
      else
        send_item(OP_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_frame();
    logic [7:0]  fc;
    logic [15:0] start;
    logic [15:0] count;
    int          nbytes;
    int          sel;
    sel = $urandom_range(99);
    fc = (sel < 45) ? FC_WRITE_MULTI : (sel < 88) ? FC_READ_HOLDING : 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 94) count = 16'($urandom_range(1, 8));
    else if (sel < 98) count = 16'($urandom_range(0, 125));
    else count = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 60) start = 16'($urandom_range(0, 31));
    else if (sel < 80) start = 16'($urandom_range(BANK_WORDS - 6, BANK_WORDS + 2));
    else start = 16'($urandom);
    nbytes = (fc == FC_WRITE_MULTI && count <= MAX_REGS) ? PAYLOAD_START + 2 * count
                                                         : HDR_BYTES;
    sel = $urandom_range(99);
    if (sel < 8) nbytes = $urandom_range(1, nbytes);
    else if (sel < 13) nbytes += $urandom_range(1, 6);
    send_frame(fc, start, count, nbytes, -1);
    // leave a response pending now and then so the next frame lands while busy
    if ($urandom_range(99) < 92) pull_response(4);
    else if ($urandom_range(1)) send_item(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_idle_tick();
    send_item(OP_TICK, 8'h00, 1'b0);
    send_item(OP_TICK, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_write_read();
    send_frame(FC_WRITE_MULTI, 16'h0000, 16'd2, PAYLOAD_START + 4, 8'hFF);
    pull_response(0);
    send_frame(FC_WRITE_MULTI, 16'h0001, 16'd1, PAYLOAD_START + 2, 8'h00);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd2, HDR_BYTES, -1);
    pull_response(0);
    // second word falls outside the bank
    send_frame(FC_WRITE_MULTI, 16'(BANK_WORDS - 1), 16'd2, PAYLOAD_START + 4, 8'hA5);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'(BANK_WORDS - 1), 16'd2, HDR_BYTES, -1);
    pull_response(0);
    send_frame(FC_WRITE_MULTI, 16'hFFFF, 16'd1, PAYLOAD_START + 2, 8'h5A);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'hFFFF, 16'd1, HDR_BYTES, -1);
    pull_response(0);
    send_frame(FC_WRITE_MULTI, 16'h0000, 16'd0, PAYLOAD_START, -1);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd0, HDR_BYTES, -1);
    pull_response(0);
    wait_drained();
  endtask

  task automatic test_special_cases();
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd1, HDR_BYTES - 1, -1);
    send_item(OP_TICK, 8'h00, 1'b0);
    send_frame(FC_READ_HOLDING, 16'h0000, MAX_REGS + 1, HDR_BYTES, -1);
    send_item(OP_TICK, 8'h00, 1'b0);
    send_frame(FC_WRITE_MULTI, 16'h0000, MAX_REGS + 1, PAYLOAD_START + 4, 8'h3C);
    send_item(OP_TICK, 8'h00, 1'b0);
    send_frame(FC_OTHER, 16'h0000, 16'd1, HDR_BYTES, -1);
    send_item(OP_TICK, 8'h00, 1'b0);
    send_frame(FC_RESERVED, 16'hFFFF, 16'hFFFF, HDR_BYTES, -1);
    send_item(OP_TICK, 8'h00, 1'b0);
    // a write frame arriving while a read response is pending must be dropped
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd2, HDR_BYTES, -1);
    send_frame(FC_WRITE_MULTI, 16'h0000, 16'd1, PAYLOAD_START + 2, 8'h33);
    send_item(OP_REQ_BYTE, 8'h12, 1'b0);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd2, HDR_BYTES, -1);
    pull_response(0);
    // receive position saturates on an overlong frame
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd1, POS_MAX + 9, -1);
    pull_response(0);
    send_frame(FC_READ_HOLDING, 16'h0000, MAX_REGS, HDR_BYTES, -1);
    pull_response(0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_len = 400;
    hold_off_seq++;
    send_frame(FC_READ_HOLDING, 16'h0000, 16'd24, HDR_BYTES, -1);
    repeat (10) send_item(OP_TICK, 8'($urandom), 1'($urandom));
    // pause the sender until the receiver has caught up
    wait_drained();
    pull_response(0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    target = useful_items + QUIET_ITEMS;
    while (useful_items < target) random_frame();
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    while (sent_items < TOTAL_ITEMS) random_frame();
  endtask

  initial begin
    for (int i = 0; i < BANK_WORDS; i++) bank_m[i] = 16'h0000;
    for (int i = 0; i < HDR_BYTES; i++) hdr_m[i] = 8'h00;
    rx_pos_m = '0;
    tx_pos_m = '0;
    tx_len_m = '0;
    busy_m = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_tick();
    test_write_read();
    test_special_cases();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
